### src/p2a_pkg.sv
// Package for the 16-bit pixel to ARGB8888 converter.
// Holds the source format codes, the channel decode types and the widening function.
package p2a_pkg;

  localparam int unsigned FmtW = 5;

  localparam logic [FmtW-1:0] FMT_RGB565   = 5'd0;
  localparam logic [FmtW-1:0] FMT_BGR565   = 5'd1;
  localparam logic [FmtW-1:0] FMT_ARGB1555 = 5'd2;
  localparam logic [FmtW-1:0] FMT_ABGR1555 = 5'd3;
  localparam logic [FmtW-1:0] FMT_RGBA5551 = 5'd4;
  localparam logic [FmtW-1:0] FMT_BGRA5551 = 5'd5;
  localparam logic [FmtW-1:0] FMT_ARGB4444 = 5'd6;
  localparam logic [FmtW-1:0] FMT_ABGR4444 = 5'd7;
  localparam logic [FmtW-1:0] FMT_RGBA4444 = 5'd8;
  localparam logic [FmtW-1:0] FMT_BGRA4444 = 5'd9;
  localparam logic [FmtW-1:0] FMT_XRGB4444 = 5'd10;
  localparam logic [FmtW-1:0] FMT_XBGR4444 = 5'd11;
  localparam logic [FmtW-1:0] FMT_RGBX4444 = 5'd12;
  localparam logic [FmtW-1:0] FMT_BGRX4444 = 5'd13;
  localparam logic [FmtW-1:0] FMT_RGB555   = 5'd14;
  localparam logic [FmtW-1:0] FMT_BGR555   = 5'd15;
  localparam logic [FmtW-1:0] FMT_RG88     = 5'd16;
  localparam logic [FmtW-1:0] FMT_GR88     = 5'd17;

  // How the raw field of one channel is widened to eight bits.
  typedef enum logic [2:0] {
    CH_ZERO,
    CH_FULL,
    CH_BIT,
    CH_W4,
    CH_W5,
    CH_W6,
    CH_W8
  } chan_kind_e;

  typedef struct packed {
    chan_kind_e  kind;
    logic [7:0]  raw;
  } chan_t;

  typedef struct packed {
    chan_t a;
    chan_t r;
    chan_t g;
    chan_t b;
  } pix_fields_t;

  function automatic logic [7:0] widen(input chan_t c);
    logic [7:0] res;
    case (c.kind)
      CH_FULL: res = 8'hFF;
      CH_BIT:  res = {8{c.raw[0]}};
      CH_W4:   res = {c.raw[3:0], c.raw[3:0]};
      CH_W5:   res = {c.raw[4:0], c.raw[4:2]};
      CH_W6:   res = {c.raw[5:0], c.raw[5:4]};
      CH_W8:   res = c.raw;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

### src/p2a_pix_if.sv
// Valid/ready channel that carries one 16-bit packed source pixel per beat.
// Standalone; no package needed.
interface p2a_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

### src/p2a_argb_if.sv
// Valid/ready channel that carries one 32-bit ARGB8888 pixel per beat.
// Standalone; no package needed.
interface p2a_argb_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_out;

  modport source (output valid, output argb_out, input ready);
  modport sink   (input valid, input argb_out, output ready);
endinterface

### src/pixel16_to_argb32_converter.sv
// Throughput: one pixel per cycle while the output is ready, set by a three-stage
// pipeline (capture, field decode, widen and pack) in which every stage moves when
// the stage after it frees.
// Reset: rst_ni clears all stage valid bits and sets the format register to RGB565.
// Depends on p2a_pkg, p2a_pix_if and p2a_argb_if.
module pixel16_to_argb32_converter
  import p2a_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             format_select_we_i,
  input  logic [FmtW-1:0]  format_select_i,
  p2a_pix_if.sink          pix_i,
  p2a_argb_if.source       argb_o
);

  // Format register. The user must write it only while the pipeline is empty; the
  // block does not enforce this. Each beat still carries its own copy of the format down the pipe.
  logic [FmtW-1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB565;
    end else if (format_select_we_i) begin
      fmt_q <= format_select_i;
    end
  end

  // Stage valid bits and per-stage advance. A stage takes new data when it is
  // empty or when its contents move on in the same cycle, so a stall at the
  // output backs up one stage at a time and no beat is dropped or repeated.
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_adv, s2_adv, s3_adv;

  assign s3_adv = !s3_vld_q || argb_o.ready;
  assign s2_adv = !s2_vld_q || s3_adv;
  assign s1_adv = !s1_vld_q || s2_adv;

  assign pix_i.ready  = s1_adv;
  assign argb_o.valid = s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_q <= pix_i.valid;
      if (s2_adv) s2_vld_q <= s1_vld_q;
      if (s3_adv) s3_vld_q <= s2_vld_q;
    end
  end

  // Stage 1: capture the pixel together with the format in force.
  logic [15:0]     s1_pix_q;
  logic [FmtW-1:0] s1_fmt_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && pix_i.valid) begin
      s1_pix_q <= pix_i.pixel_in;
      s1_fmt_q <= fmt_q;
    end
  end

  // Stage 2: pick out the raw bits of each channel and tag how each one widens.
  pix_fields_t s2_fld_d, s2_fld_q;

  function automatic chan_t mk(input chan_kind_e k, input logic [7:0] v);
    chan_t c;
    c.kind = k;
    c.raw  = v;
    return c;
  endfunction

  always_comb begin
    logic [15:0] p;
    p = s1_pix_q;
    s2_fld_d.a = mk(CH_ZERO, 8'h00);
    s2_fld_d.r = mk(CH_ZERO, 8'h00);
    s2_fld_d.g = mk(CH_ZERO, 8'h00);
    s2_fld_d.b = mk(CH_ZERO, 8'h00);
    case (s1_fmt_q)
      FMT_RGB565: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W5, {3'b0, p[15:11]});
        s2_fld_d.g = mk(CH_W6, {2'b0, p[10:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[4:0]});
      end
      FMT_BGR565: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W5, {3'b0, p[4:0]});
        s2_fld_d.g = mk(CH_W6, {2'b0, p[10:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[15:11]});
      end
      FMT_ARGB1555: begin
        s2_fld_d.a = mk(CH_BIT, {7'b0, p[15]});
        s2_fld_d.r = mk(CH_W5, {3'b0, p[14:10]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[9:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[4:0]});
      end
      FMT_ABGR1555: begin
        s2_fld_d.a = mk(CH_BIT, {7'b0, p[15]});
        s2_fld_d.r = mk(CH_W5, {3'b0, p[4:0]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[9:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[14:10]});
      end
      FMT_RGBA5551: begin
        s2_fld_d.a = mk(CH_BIT, {7'b0, p[0]});
        s2_fld_d.r = mk(CH_W5, {3'b0, p[15:11]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[10:6]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[5:1]});
      end
      FMT_BGRA5551: begin
        s2_fld_d.a = mk(CH_BIT, {7'b0, p[0]});
        s2_fld_d.r = mk(CH_W5, {3'b0, p[5:1]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[10:6]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[15:11]});
      end
      FMT_ARGB4444: begin
        s2_fld_d.a = mk(CH_W4, {4'b0, p[15:12]});
        s2_fld_d.r = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[3:0]});
      end
      FMT_ABGR4444: begin
        s2_fld_d.a = mk(CH_W4, {4'b0, p[15:12]});
        s2_fld_d.r = mk(CH_W4, {4'b0, p[3:0]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[11:8]});
      end
      FMT_RGBA4444: begin
        s2_fld_d.a = mk(CH_W4, {4'b0, p[3:0]});
        s2_fld_d.r = mk(CH_W4, {4'b0, p[15:12]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[7:4]});
      end
      FMT_BGRA4444: begin
        s2_fld_d.a = mk(CH_W4, {4'b0, p[3:0]});
        s2_fld_d.r = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[15:12]});
      end
      FMT_XRGB4444: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[3:0]});
      end
      FMT_XBGR4444: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W4, {4'b0, p[3:0]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[11:8]});
      end
      FMT_RGBX4444: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W4, {4'b0, p[15:12]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[7:4]});
      end
      FMT_BGRX4444: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W4, {4'b0, p[7:4]});
        s2_fld_d.g = mk(CH_W4, {4'b0, p[11:8]});
        s2_fld_d.b = mk(CH_W4, {4'b0, p[15:12]});
      end
      FMT_RGB555: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W5, {3'b0, p[14:10]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[9:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[4:0]});
      end
      FMT_BGR555: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W5, {3'b0, p[4:0]});
        s2_fld_d.g = mk(CH_W5, {3'b0, p[9:5]});
        s2_fld_d.b = mk(CH_W5, {3'b0, p[14:10]});
      end
      FMT_RG88: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W8, p[15:8]);
        s2_fld_d.g = mk(CH_W8, p[7:0]);
      end
      FMT_GR88: begin
        s2_fld_d.a = mk(CH_FULL, 8'h00);
        s2_fld_d.r = mk(CH_W8, p[7:0]);
        s2_fld_d.g = mk(CH_W8, p[15:8]);
      end
      default: begin
        // Unused format codes give an all-zero pixel, alpha included.
        s2_fld_d.a = mk(CH_ZERO, 8'h00);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      s2_fld_q <= s2_fld_d;
    end
  end

  // Stage 3: widen every channel by bit replication and pack ARGB8888. This
  // register is the output register. While a finished pixel waits for the sink,
  // the two stages in front of it can still fill, so up to two more beats are
  // taken before the input side stalls.
  logic [31:0] s3_argb_d, s3_argb_q;

  assign s3_argb_d = {widen(s2_fld_q.a), widen(s2_fld_q.r),
                      widen(s2_fld_q.g), widen(s2_fld_q.b)};

  always_ff @(posedge clk_i) begin
    if (s3_adv && s2_vld_q) begin
      s3_argb_q <= s3_argb_d;
    end
  end

  assign argb_o.argb_out = s3_argb_q;

endmodule

### tb/sv/pixel16_to_argb32_converter_tb.sv
// Self-checking testbench for pixel16_to_argb32_converter: drives 16-bit pixels under
// every source format and checks each ARGB8888 beat against a built-in predictor.
// Depends on p2a_pkg, p2a_pix_if, p2a_argb_if and the converter RTL.
module pixel16_to_argb32_converter_tb;
  import p2a_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes past the last defined layout. The block must answer them with an all-zero pixel.
  localparam logic [FmtW-1:0] FMT_UNUSED_FIRST = 5'd18;
  localparam logic [FmtW-1:0] FMT_UNUSED_LAST  = 5'd31;

  // The pipeline is three stages deep. Idle checks wait a little longer than that.
  localparam int unsigned PipeDepth  = 3;
  localparam int unsigned MaxWait    = 11;
  localparam int unsigned RandPhases = 24;

  // These are bit patterns with mixed ones and zeros in every nibble. The per-format
  // directed beats use them.
  localparam logic [15:0] PROBE [4] = '{16'hA5C3, 16'h5A3C, 16'h8421, 16'h7BDE};

  logic            clk_i;
  logic            rst_ni;
  logic            format_select_we;
  logic [FmtW-1:0] format_select;

  p2a_pix_if  pix ();
  p2a_argb_if argb ();

  pixel16_to_argb32_converter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .format_select_we_i (format_select_we),
    .format_select_i    (format_select),
    .pix_i              (pix),
    .argb_o             (argb)
  );

  // This is the testbench's own copy of the format register. It changes only while the
  // pipeline is empty.
  logic [FmtW-1:0] active_format;
  // These are the expected output pixels, oldest first.
  logic [31:0]     expected_argb [$];
  int unsigned     mismatches;
  // When one of these is cleared, that side of the link runs without gaps.
  bit              src_gaps;
  bit              snk_stalls;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // These functions widen a channel by bit replication.
  function automatic logic [7:0] rep4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] rep5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rep6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // The predictor decodes one packed pixel in the given layout and returns ARGB8888.
  // A one-bit alpha is smeared over all eight bits. Layouts without alpha give 0xFF.
  // The two-channel layouts give blue 0x00. Undefined codes give an all-zero pixel.
  function automatic logic [31:0] argb_from_pixel(input logic [FmtW-1:0] fmt,
                                                  input logic [15:0] px);
    logic [7:0] n0, n1, n2, n3;
    logic [31:0] res;
    n0 = rep4(px[3:0]);
    n1 = rep4(px[7:4]);
    n2 = rep4(px[11:8]);
    n3 = rep4(px[15:12]);
    case (fmt)
      FMT_RGB565:   res = {8'hFF, rep5(px[15:11]), rep6(px[10:5]), rep5(px[4:0])};
      FMT_BGR565:   res = {8'hFF, rep5(px[4:0]), rep6(px[10:5]), rep5(px[15:11])};
      FMT_ARGB1555: res = {{8{px[15]}}, rep5(px[14:10]), rep5(px[9:5]), rep5(px[4:0])};
      FMT_ABGR1555: res = {{8{px[15]}}, rep5(px[4:0]), rep5(px[9:5]), rep5(px[14:10])};
      FMT_RGBA5551: res = {{8{px[0]}}, rep5(px[15:11]), rep5(px[10:6]), rep5(px[5:1])};
      FMT_BGRA5551: res = {{8{px[0]}}, rep5(px[5:1]), rep5(px[10:6]), rep5(px[15:11])};
      FMT_ARGB4444: res = {n3, n2, n1, n0};
      FMT_ABGR4444: res = {n3, n0, n1, n2};
      FMT_RGBA4444: res = {n0, n3, n2, n1};
      FMT_BGRA4444: res = {n0, n1, n2, n3};
      FMT_XRGB4444: res = {8'hFF, n2, n1, n0};
      FMT_XBGR4444: res = {8'hFF, n0, n1, n2};
      FMT_RGBX4444: res = {8'hFF, n3, n2, n1};
      FMT_BGRX4444: res = {8'hFF, n1, n2, n3};
      FMT_RGB555:   res = {8'hFF, rep5(px[14:10]), rep5(px[9:5]), rep5(px[4:0])};
      FMT_BGR555:   res = {8'hFF, rep5(px[4:0]), rep5(px[9:5]), rep5(px[14:10])};
      FMT_RG88:     res = {8'hFF, px[15:8], px[7:0], 8'h00};
      FMT_GR88:     res = {8'hFF, px[7:0], px[15:8], 8'h00};
      default:      res = 32'h0000_0000;
    endcase
    return res;
  endfunction

  // This task offers one pixel after a random gap and holds it until the block takes it.
  // The expectation is recorded at the edge that accepts the beat. Valid stays high when
  // the next beat follows with no gap.
  task automatic send_pixel(input logic [15:0] px);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MaxWait) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.pixel_in <= px;
    do @(posedge clk_i); while (!pix.ready);
    expected_argb.push_back(argb_from_pixel(active_format, px));
  endtask

  // This task stops offering beats and waits until every expected pixel has come out.
  // It then waits longer still so that nothing is left in flight.
  task automatic drain_pipeline();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (expected_argb.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // The format register is written only with the pipeline empty, so every beat in flight
  // is converted under a single layout.
  task automatic load_format(input logic [FmtW-1:0] fmt);
    drain_pipeline();
    @(negedge clk_i);
    format_select_we <= 1'b1;
    format_select    <= fmt;
    active_format     = fmt;
    @(negedge clk_i);
    format_select_we <= 1'b0;
  endtask

  // This test uses the reset layout, RGB565, before any register write. It sends the
  // extremes of the pixel and each channel field on its own.
  task automatic test_reset_format();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
  endtask

  // This test sends one beat under every defined layout except RGB565, which the reset test
  // covers, and under both ends of the undefined range. The layouts ignore different unused
  // bits, and the probe patterns keep a bit set in each unused field but that of BGR555.
  task automatic test_each_format();
    for (int f = FMT_BGR565; f <= FMT_GR88; f++) begin
      load_format(f[FmtW-1:0]);
      send_pixel(PROBE[f % 4]);
    end
    load_format(FMT_UNUSED_FIRST);
    send_pixel(16'hFFFF);
    load_format(FMT_UNUSED_LAST);
    send_pixel(16'hFFFF);
  endtask

  // This test runs phases of random pixels. Each phase uses a random layout and its own
  // choice of gaps on each side. The first phases use the two extreme register values
  // and the last defined layout. Some phases run back to back on one side or on both.
  task automatic test_random_formats();
    logic [FmtW-1:0] fmt;
    logic [15:0]     px;
    int unsigned     beats;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       fmt = FMT_RGB565;
        1:       fmt = FMT_UNUSED_LAST;
        2:       fmt = FMT_GR88;
        default: begin
          if ($urandom_range(0, 7) == 0)
            fmt = FmtW'($urandom_range(FMT_UNUSED_FIRST, FMT_UNUSED_LAST));
          else
            fmt = FmtW'($urandom_range(FMT_RGB565, FMT_GR88));
        end
      endcase
      load_format(fmt);
      src_gaps   = ($urandom_range(0, 3) != 0);
      snk_stalls = ($urandom_range(0, 3) != 0);
      beats      = $urandom_range(60, 100);
      for (int k = 0; k < beats; k++) begin
        // Most pixels are fully random. The rest are all zeros, all ones, a single set
        // bit or a single clear bit.
        case ($urandom_range(0, 9))
          0:       px = 16'h0000;
          1:       px = 16'hFFFF;
          2:       px = 16'h0001 << $urandom_range(0, 15);
          3:       px = ~(16'h0001 << $urandom_range(0, 15));
          default: px = 16'($urandom_range(0, 16'hFFFF));
        endcase
        send_pixel(px);
      end
    end
  endtask

  // The output side stalls for a random number of cycles before each beat. It then
  // checks the beat against the oldest expectation. A beat with nothing expected is a
  // failure too.
  initial begin
    int unsigned stall;
    logic [31:0] want;
    argb.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = snk_stalls ? $urandom_range(0, MaxWait) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        argb.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      argb.ready <= 1'b1;
      do @(posedge clk_i); while (!argb.valid);
      if (expected_argb.size() == 0) begin
        $error("argb_out: unexpected beat, actual %08h", argb.argb_out);
        mismatches++;
      end else begin
        want = expected_argb.pop_front();
        if (argb.argb_out !== want) begin
          $error("argb_out mismatch: expected %08h, actual %08h", want, argb.argb_out);
          mismatches++;
        end
      end
    end
  end

  // This block ends a run that hangs. Its limit is far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("pixel16_to_argb32_converter_tb: FAIL");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    format_select_we = 1'b0;
    format_select    = FMT_RGB565;
    pix.valid        = 1'b0;
    pix.pixel_in     = 16'h0000;
    active_format    = FMT_RGB565;
    mismatches       = 0;
    src_gaps         = 1'b1;
    snk_stalls       = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_format();
    test_each_format();
    test_random_formats();

    drain_pipeline();
    if (mismatches == 0)
      $display("pixel16_to_argb32_converter_tb: PASS");
    else
      $display("pixel16_to_argb32_converter_tb: FAIL");
    $finish;
  end

endmodule
